FILE: rtl/core/adl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_pkg: shared types and constants for the adler-32 unit
// modulus, field widths, lane result and accumulator control types and the modular reduction helper
// ----------------------------------------------------------------------------
package adl_pkg;

  localparam int unsigned ADLER_MOD   = 65521;
  localparam int unsigned MAX_LANES   = 16;
  localparam int unsigned DEF_LANES   = 8;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned DATA_BYTES  = DATA_W / 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned CHK_W       = 2 * SUM_W;
  // widest weighted byte: 255 * MAX_LANES
  localparam int unsigned WBYTE_W     = 12;
  // sum of raw bytes over all lanes: 255 * MAX_LANES
  localparam int unsigned SUMA_W      = 12;
  // sum of weighted bytes: 255 * MAX_LANES * (MAX_LANES + 1) / 2
  localparam int unsigned SUMB_W      = 16;
  // b + n * a + weighted sum before reduction
  localparam int unsigned RED_W       = 21;

  localparam logic [SUM_W-1:0] MOD_VAL = SUM_W'(ADLER_MOD);
  localparam logic [SUM_W-1:0] A_INIT  = SUM_W'(1);
  localparam logic [SUM_W-1:0] B_INIT  = SUM_W'(0);

  typedef struct packed {
    logic [7:0]         byte_v;   // lane byte, zero when unused
    logic [WBYTE_W-1:0] wbyte;    // byte times its weight toward sum b
  } lane_out_t;

  typedef struct packed {
    logic take;   // accumulator consumes the staged beat
    logic last;   // staged beat closes the message
  } acc_ctl_t;

  // 2^16 mod 65521 is 15, so fold the upper bits back in and subtract once
  function automatic logic [SUM_W-1:0] mod_reduce(input logic [RED_W-1:0] x);
    logic [RED_W-SUM_W-1:0] hi;
    logic [SUM_W:0]         y;
    hi = x[RED_W-1:SUM_W];
    y  = {1'b0, x[SUM_W-1:0]} + ((SUM_W+1)'(hi) * (SUM_W+1)'(15));
    if (y >= (SUM_W+1)'(ADLER_MOD)) begin
      y = y - (SUM_W+1)'(ADLER_MOD);
    end
    return y[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/core/adl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_lane: one byte lane
// picks its byte, weights it by its distance from the end of the beat and
// registers both for the merge stage
// ----------------------------------------------------------------------------
module adl_lane #(
  parameter int unsigned LANES    = adl_pkg::DEF_LANES,
  parameter int unsigned LANE_IDX = 0
) (
  input  logic                             clk,
  input  logic                             load_i,
  input  logic [adl_pkg::DATA_W-1:0]       data_i,
  input  logic [$clog2(LANES+1)-1:0]       cnt_i,
  output adl_pkg::lane_out_t               lane_o
);

  localparam int unsigned CNT_W = $clog2(LANES + 1);

  logic [7:0]                     byte_sel;
  logic [CNT_W-1:0]               weight;
  logic                           used;
  adl_pkg::lane_out_t             lane_nxt;
  adl_pkg::lane_out_t             lane_r;

  // lanes past the data word read as zero bytes
  generate
    if (LANE_IDX < adl_pkg::DATA_BYTES) begin : g_data
      assign byte_sel = data_i[8*LANE_IDX +: 8];
    end else begin : g_zero
      assign byte_sel = 8'd0;
    end
  endgenerate

  always_comb begin
    used            = (CNT_W+1)'(cnt_i) > (CNT_W+1)'(LANE_IDX);
    weight          = used ? (cnt_i - CNT_W'(LANE_IDX)) : '0;
    lane_nxt.byte_v = used ? byte_sel : 8'd0;
    lane_nxt.wbyte  = adl_pkg::WBYTE_W'(byte_sel) * adl_pkg::WBYTE_W'(weight);
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

FILE: rtl/core/adl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_merge: lane merge and running sums
// adds the lane results and folds them into sum a and sum b modulo 65521
// ----------------------------------------------------------------------------
module adl_merge #(
  parameter int unsigned LANES = adl_pkg::DEF_LANES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  adl_pkg::acc_ctl_t                ctl_i,
  input  logic [$clog2(LANES+1)-1:0]       cnt_i,
  input  adl_pkg::lane_out_t               lanes_i [LANES],
  output logic [adl_pkg::CHK_W-1:0]        chk_o
);

  logic [adl_pkg::SUMA_W-1:0] sum_bytes;
  logic [adl_pkg::SUMB_W-1:0] sum_wbytes;
  logic [adl_pkg::RED_W-1:0]  a_raw;
  logic [adl_pkg::RED_W-1:0]  b_raw;
  logic [adl_pkg::SUM_W-1:0]  a_upd;
  logic [adl_pkg::SUM_W-1:0]  b_upd;
  logic [adl_pkg::SUM_W-1:0]  sum_a_r;
  logic [adl_pkg::SUM_W-1:0]  sum_a_nxt;
  logic [adl_pkg::SUM_W-1:0]  sum_b_r;
  logic [adl_pkg::SUM_W-1:0]  sum_b_nxt;

  always_comb begin
    sum_bytes  = '0;
    sum_wbytes = '0;
    for (int k = 0; k < LANES; k++) begin
      sum_bytes  = sum_bytes + adl_pkg::SUMA_W'(lanes_i[k].byte_v);
      sum_wbytes = sum_wbytes + adl_pkg::SUMB_W'(lanes_i[k].wbyte);
    end
  end

  // a' = a + sum(byte), b' = b + n * a + sum(weight * byte)
  always_comb begin
    a_raw = adl_pkg::RED_W'(sum_a_r) + adl_pkg::RED_W'(sum_bytes);
    b_raw = adl_pkg::RED_W'(sum_b_r)
          + adl_pkg::RED_W'(cnt_i) * adl_pkg::RED_W'(sum_a_r)
          + adl_pkg::RED_W'(sum_wbytes);
    a_upd = adl_pkg::mod_reduce(a_raw);
    b_upd = adl_pkg::mod_reduce(b_raw);
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (ctl_i.take) begin
      sum_a_nxt = ctl_i.last ? adl_pkg::A_INIT : a_upd;
      sum_b_nxt = ctl_i.last ? adl_pkg::B_INIT : b_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= adl_pkg::A_INIT;
      sum_b_r <= adl_pkg::B_INIT;
    end else begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  assign chk_o = {b_upd, a_upd};

endmodule

FILE: rtl/core/adler32_checksum_8byte_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adler32_checksum_8byte_unit: adler-32 over beats of up to LANES bytes
// lane stage weights each byte, merge stage updates both sums,
// output register holds the checksum until the sink takes it
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      sink       in_valid/in_stall  in_data_bytes, in_byte_count, in_last
//  out_     source     out_valid/out_stall out_checksum
//
//  one beat per cycle unless a last beat waits on a stalled checksum; the running-sum
//    feedback (n * a plus a modular fold) closes combinationally in the merge stage
//  a checksum passes through the lane stage and then the output register after
//    its last beat is accepted; a stalled earlier checksum can hold it in the lane stage
//  rst_n is synchronous and active low; sums return to a = 1, b = 0
//  a stalled checksum holds the merge stage only when the next staged beat
//    is also a last beat; other beats keep flowing
//
module adler32_checksum_8byte_unit #(
  parameter int unsigned LANES = adl_pkg::DEF_LANES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [adl_pkg::DATA_W-1:0]        in_data_bytes,
  input  logic [adl_pkg::COUNT_W-1:0]       in_byte_count,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [adl_pkg::CHK_W-1:0]         out_checksum
);

  localparam int unsigned CNT_W = $clog2(LANES + 1);

  // accepted beat and stage control
  logic                         in_take;
  logic                         stg_move;
  logic                         out_free;
  logic [CNT_W-1:0]             cnt_sat;

  // lane stage
  logic                         stg_valid_r;
  logic                         stg_valid_nxt;
  logic                         stg_last_r;
  logic [CNT_W-1:0]             stg_cnt_r;
  adl_pkg::lane_out_t           lane_res [LANES];

  // merge and output
  adl_pkg::acc_ctl_t            acc_ctl;
  logic [adl_pkg::CHK_W-1:0]    chk_upd;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [adl_pkg::CHK_W-1:0]    out_chk_r;

  // counts above the lane count saturate
  always_comb begin
    if ((adl_pkg::COUNT_W+1)'(in_byte_count) > (adl_pkg::COUNT_W+1)'(LANES)) begin
      cnt_sat = CNT_W'(LANES);
    end else begin
      cnt_sat = CNT_W'(in_byte_count);
    end
  end

  // a last beat may only leave the lane stage when the output slot frees up
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    stg_move      = stg_valid_r && (!stg_last_r || out_free);
    in_stall      = stg_valid_r && !stg_move;
    in_take       = in_valid && !in_stall;
    stg_valid_nxt = in_take || (stg_valid_r && !stg_move);
    out_valid_nxt = (stg_move && stg_last_r) || (out_valid_r && out_stall);
    acc_ctl.take  = stg_move;
    acc_ctl.last  = stg_last_r;
  end

  generate
    for (genvar g = 0; g < LANES; g++) begin : g_lane
      adl_lane #(
        .LANES    (LANES),
        .LANE_IDX (g)
      ) u_lane (
        .clk    (clk),
        .load_i (in_take),
        .data_i (in_data_bytes),
        .cnt_i  (cnt_sat),
        .lane_o (lane_res[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // staged beat side info, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_cnt_r  <= cnt_sat;
      stg_last_r <= in_last;
    end
  end

  adl_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (acc_ctl),
    .cnt_i   (stg_cnt_r),
    .lanes_i (lane_res),
    .chk_o   (chk_upd)
  );

  // checksum captured as the last beat folds in
  always_ff @(posedge clk) begin
    if (stg_move && stg_last_r) begin
      out_chk_r <= chk_upd;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_chk_r;

endmodule

FILE: rtl/core/adl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_checker: port-level checks for the adler-32 unit
// watches reset, input stall cause, result hold under stall and checksum range
// ----------------------------------------------------------------------------
module adl_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [adl_pkg::CHK_W-1:0]         out_checksum
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum))
    else $error("stalled result beat dropped or changed");

  // both sums are fully reduced
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_checksum[15:0] < 16'(adl_pkg::ADLER_MOD))
               && (out_checksum[31:16] < 16'(adl_pkg::ADLER_MOD)))
    else $error("checksum half not reduced");

  // input only backs up while a result is held by the sink
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind adler32_checksum_8byte_unit adl_checker u_adl_checker (.*);
